/* src/tsg_pkg.sv */
// Shared types and constants of the touch stroke gesture recognizer.
package tsg_pkg;

    localparam logic [2:0] REQ_X     = 3'd0;
    localparam logic [2:0] REQ_Y     = 3'd1;
    localparam logic [2:0] REQ_ID    = 3'd2;
    localparam logic [2:0] REQ_SLOT  = 3'd3;
    localparam logic [2:0] REQ_BTN   = 3'd4;

    localparam logic [1:0] CFG_ARMED = 2'd0;
    localparam logic [1:0] CFG_MASK  = 2'd1;
    localparam logic [1:0] CFG_STEP  = 2'd2;

    localparam logic [1:0] GEST_NONE = 2'd0;
    localparam logic [1:0] GEST_O    = 2'd1;
    localparam logic [1:0] GEST_E    = 2'd2;
    localparam logic [1:0] GEST_M    = 2'd3;

    localparam logic [16:0] ID_NONE  = 17'h1FFFF;

    localparam logic [7:0] DIR_R  = 8'd1;
    localparam logic [7:0] DIR_RU = 8'd2;
    localparam logic [7:0] DIR_U  = 8'd4;
    localparam logic [7:0] DIR_LU = 8'd8;
    localparam logic [7:0] DIR_L  = 8'd16;
    localparam logic [7:0] DIR_LD = 8'd32;
    localparam logic [7:0] DIR_D  = 8'd64;
    localparam logic [7:0] DIR_RD = 8'd128;

    // Rotate a one-hot direction code counterclockwise by n eighths.
    function automatic logic [7:0] rot_ccw(input logic [7:0] d, input logic [2:0] n);
        logic [15:0] w;
        w = {d, d} << n;
        return w[15:8];
    endfunction

    // Octant index of a one-hot code.
    function automatic logic [2:0] dir_idx(input logic [7:0] d);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (d[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

/* src/tsg_classifier.sv */
// Sequential walk over the stroke history that classifies o, e and m.
module tsg_classifier #(
    parameter int HISTORY_DEPTH = 15,
    parameter int COORD_BITS    = 12
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [$clog2(HISTORY_DEPTH+1)-1:0]   count,
    input  logic [2:0]                           gesture_mask,
    input  logic [COORD_BITS-1:0]                latest_x,
    input  logic [COORD_BITS-1:0]                latest_y,
    input  logic [COORD_BITS-1:0]                start_x,
    input  logic [COORD_BITS-1:0]                start_y,
    input  logic [HISTORY_DEPTH-1:0][7:0]        hist,
    input  logic [HISTORY_DEPTH-1:0][COORD_BITS-1:0] cy_store,
    output logic                                 done,
    output logic [1:0]                           gesture
);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int IW = $clog2(HISTORY_DEPTH);

    typedef enum logic [1:0] {C_IDLE, C_WALK, C_DONE} cstate_t;

    cstate_t             state_reg;
    logic [CW-1:0]       i_reg;
    logic [12:0]         total_reg;
    logic signed [1:0]   turn_reg;
    logic [12:0]         osum_reg;
    logic [COORD_BITS:0] lowy_reg;
    logic                o_live_reg, o_hit_reg;
    logic [12:0]         msum_reg;
    logic                lower_reg, m_live_reg, m_hit_reg;

    logic [IW-1:0] ia, ib;
    logic [7:0]    g, n;
    logic          has_next;
    assign ia = i_reg[IW-1:0];
    assign ib = (i_reg + CW'(1) < CW'(HISTORY_DEPTH)) ? IW'(i_reg + CW'(1)) : ia;
    assign g  = hist[ia];
    assign n  = hist[ib];
    assign has_next = (i_reg + CW'(1) < count);

    logic         o_hit_now;
    logic signed [1:0] turn_next;
    logic [12:0]  osum_next;
    logic [COORD_BITS:0] lowy_next;
    logic         ccw_g, cw_g;
    logic [COORD_BITS-1:0] cy;
    always_comb begin
        ccw_g = (9'({g, 1'b0}) == 9'(n)) || (g == 8'd128 && n == 8'd1);
        cw_g  = (9'(g) == 9'({n, 1'b0})) || (n == 8'd128 && g == 8'd1);
        turn_next = turn_reg;
        o_hit_now = 1'b0;
        if (ccw_g && turn_reg < 2'sd1) begin
            turn_next = -2'sd1;
            o_hit_now = 1'b1;
        end else if (cw_g && turn_reg > -2'sd1) begin
            turn_next = 2'sd1;
            o_hit_now = 1'b1;
        end
        osum_next = osum_reg;
        lowy_next = lowy_reg;
        cy = cy_store[ia];
        if (o_hit_now) begin
            osum_next = osum_reg + 13'(g);
            if (cy != '0 && (COORD_BITS+1)'(cy) > lowy_reg) begin
                lowy_next = (COORD_BITS+1)'(cy);
            end
        end
    end

    logic [12:0]   msum_next;
    logic          lower_next, skip_m, m_match;
    logic [CW-1:0] k;
    always_comb begin
        msum_next  = msum_reg;
        lower_next = lower_reg;
        skip_m     = 1'b0;
        if (!lower_reg && (cw_g || (g == 8'd64 && n == 8'd4))) begin
            msum_next = msum_reg + 13'(g);
            if (i_reg + CW'(2) == count) begin
                msum_next = msum_next + 13'(n);
                skip_m    = 1'b1;
            end
        end else if (!lower_reg && g == 8'd64 && n == 8'd128 &&
                     (msum_reg + 13'd64 == 13'd199 || msum_reg + 13'd64 == 13'd195)) begin
            msum_next  = msum_reg + 13'(g);
            lower_next = 1'b1;
        end else if (lower_reg && ((g == 8'd128 && n == 8'd1) || (g == 8'd1 && n == 8'd2))) begin
            msum_next = msum_reg + 13'(g);
            if (msum_next == 13'd328 && g == 8'd1) begin
                lower_next = 1'b0;
            end
        end
        k = skip_m ? (i_reg + CW'(1)) : i_reg;
        m_match = (msum_next == 13'd398 && k == CW'(9)) ||
                  (msum_next == 13'd394 && k == CW'(8)) ||
                  (msum_next == 13'd334 && k == CW'(8)) ||
                  (msum_next == 13'd330 && k == CW'(7)) ||
                  (msum_next == 13'd529 && k == CW'(12)) ||
                  (msum_next == 13'd525 && k == CW'(11)) ||
                  (msum_next == 13'd465 && k == CW'(11)) ||
                  (msum_next == 13'd461 && k == CW'(10));
    end

    logic [COORD_BITS:0] dxa, dya;
    logic [1:0]          gsel;
    logic                e_ok, o_ok, m_ok;
    always_comb begin
        dxa = (latest_x >= start_x) ? (COORD_BITS+1)'(latest_x - start_x)
                                    : (COORD_BITS+1)'(start_x - latest_x);
        dya = (latest_y >= start_y) ? (COORD_BITS+1)'(latest_y - start_y)
                                    : (COORD_BITS+1)'(start_y - latest_y);
        o_ok = count > CW'(8) && o_hit_reg && gesture_mask[1];
        e_ok = dxa > (COORD_BITS+1)'(40) && dya > (COORD_BITS+1)'(40) && gesture_mask[0] &&
               ((count == CW'(9) && total_reg == 13'd256) ||
                (count == CW'(8) && total_reg == 13'd255) ||
                (count == CW'(7) && total_reg == 13'd254));
        m_ok = m_hit_reg && gesture_mask[2];
        gsel = tsg_pkg::GEST_NONE;
        if (o_ok) begin
            gsel = tsg_pkg::GEST_O;
        end else if (count > CW'(6)) begin
            if (e_ok) begin
                gsel = tsg_pkg::GEST_E;
            end else if (m_ok) begin
                gsel = tsg_pkg::GEST_M;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
        end else begin
            case (state_reg)
                C_IDLE: begin
                    if (start) begin
                        state_reg  <= (count == '0) ? C_DONE : C_WALK;
                        i_reg      <= '0;
                        total_reg  <= '0;
                        turn_reg   <= 2'sd0;
                        osum_reg   <= '0;
                        lowy_reg   <= '0;
                        o_live_reg <= 1'b1;
                        o_hit_reg  <= 1'b0;
                        msum_reg   <= '0;
                        lower_reg  <= 1'b0;
                        m_live_reg <= 1'b1;
                        m_hit_reg  <= 1'b0;
                    end
                end
                C_WALK: begin
                    total_reg <= total_reg + 13'(g);
                    if (has_next) begin
                        if (o_live_reg) begin
                            turn_reg <= turn_next;
                            osum_reg <= osum_next;
                            lowy_reg <= lowy_next;
                            if (osum_next == 13'd255 &&
                                (COORD_BITS+2)'(latest_y) < (COORD_BITS+2)'(lowy_next) + 50) begin
                                o_hit_reg  <= 1'b1;
                                o_live_reg <= 1'b0;
                            end else if (osum_next > 13'd255) begin
                                o_live_reg <= 1'b0;
                            end
                        end
                        if (m_live_reg && !skip_m) begin
                            msum_reg  <= msum_next;
                            lower_reg <= lower_next;
                            if (m_match) begin
                                m_hit_reg  <= 1'b1;
                                m_live_reg <= 1'b0;
                            end
                        end else if (m_live_reg) begin
                            msum_reg   <= msum_next;
                            m_live_reg <= 1'b0;
                            m_hit_reg  <= m_match;
                        end
                    end
                    i_reg <= i_reg + CW'(1);
                    if (i_reg + CW'(1) >= count) begin
                        state_reg <= C_DONE;
                    end
                end
                C_DONE: begin
                    state_reg <= C_IDLE;
                end
                default: state_reg <= C_IDLE;
            endcase
        end
    end

    assign done    = (state_reg == C_DONE);
    assign gesture = (count == '0) ? tsg_pkg::GEST_NONE : gsel;

    property p_walk_index;
        @(posedge aclk) disable iff (!aresetn) (state_reg == C_WALK) |-> (i_reg < count);
    endproperty
    a_walk: assert property (p_walk_index) else $error("walk index past count");
    property p_start_leaves_idle;
        @(posedge aclk) disable iff (!aresetn) (state_reg == C_IDLE && start) |=> state_reg != C_IDLE;
    endproperty
    a_start: assert property (p_start_leaves_idle) else $error("start ignored");
    property p_done_one;
        @(posedge aclk) disable iff (!aresetn) done |=> !done;
    endproperty
    a_done: assert property (p_done_one) else $error("done held");
    property p_live;
        @(posedge aclk) disable iff (!aresetn) (state_reg == C_WALK && o_hit_reg) |-> !o_live_reg;
    endproperty
    a_live: assert property (p_live) else $error("o walk still live after hit");
endmodule

/* src/touch_stroke_gesture_recognizer.sv */
// Top level of the touch stroke gesture recognizer.
// The s_ channel takes touch events: tdata[2:0] req_type, tdata[19:3] value.
// The m_ channel gives one result beat per lift while armed: tdata[1:0] gesture,
// tdata[5:2] stroke_count. Registers are written through cfg_valid/cfg_ready
// with cfg_index (0 armed, 1 gesture_mask, 2 min_step) and cfg_data; cfg_ready
// is always high.
// The block works on one beat at a time and holds s_tready low meanwhile.
// A beat that completes no point, and any beat while disarmed, passes through S_EVT
// only before the next beat is accepted. The beat that completes a point runs the
// shared multiplier and direction sequencer (S_PT, S_SQX, S_SQY, S_DIR), and also
// S_FILL and S_APP when a new direction is appended to the history.
// A lift walks the history one entry a cycle; the result beat follows the walk,
// and the next beat is taken once S_OUT has cleared the history.
// A result beat sits in the output register until taken; events go on being
// accepted meanwhile, and only the next lift waits until that register is free.
// Reset clears all history and sets the registers to armed 0, mask 7, step 5.
// No clearing pass follows reset.
module touch_stroke_gesture_recognizer #(
    parameter int HISTORY_DEPTH = 15,
    parameter int COORD_BITS    = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // req_type[2:0], value[19:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // gesture[1:0], stroke_count[5:2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int PW = COORD_BITS + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_EVT, S_PT, S_SQX, S_SQY, S_DIR, S_FILL, S_APP, S_CLS, S_OUT
    } state_t;

    state_t state_reg;
    logic armed_reg;
    logic [2:0] mask_reg;
    logic [7:0] step_reg;

    logic [2:0]  kind_reg;
    logic [16:0] raw_reg;

    logic [HISTORY_DEPTH-1:0][7:0]            hist_reg;
    logic [HISTORY_DEPTH-1:0][COORD_BITS-1:0] cx_reg, cy_reg;
    logic [CW-1:0] nstr_reg, ncor_reg;
    logic [COORD_BITS-1:0] sx_reg, sy_reg, lx_reg, ly_reg, tx_reg, ty_reg, px_reg, py_reg;
    logic [7:0]  prev_reg;
    logic        xs_reg, ys_reg, havep_reg;
    logic [16:0] cid_reg;

    logic signed [PW:0] dx_reg, dy_reg;
    logic [PW-1:0] ax_reg, ay_reg;
    logic [2*PW:0] sq_reg;
    logic [7:0]    d0_reg, d1_reg, d2_reg;

    logic        mv_reg;
    logic [7:0]  mdata_reg;

    logic [PW-1:0]   mul_a;
    logic [2*PW-1:0] mul_p;
    assign mul_a = (state_reg == S_SQX) ? ax_reg : ay_reg;
    assign mul_p = mul_a * mul_a;

    logic cls_busy_reg;
    logic cls_start, cls_done;
    logic [1:0] cls_gest;
    tsg_classifier #(.HISTORY_DEPTH(HISTORY_DEPTH), .COORD_BITS(COORD_BITS)) u_cls (
        .aclk(aclk), .aresetn(aresetn), .start(cls_start), .count(nstr_reg),
        .gesture_mask(mask_reg), .latest_x(tx_reg), .latest_y(ty_reg),
        .start_x(sx_reg), .start_y(sy_reg), .hist(hist_reg), .cy_store(cy_reg),
        .done(cls_done), .gesture(cls_gest)
    );
    assign cls_start = (state_reg == S_CLS) && !cls_busy_reg && (!mv_reg || m_tready);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;

    // Direction of the move.
    logic        slanted, bigsq;
    logic [7:0]  d0c;
    always_comb begin
        slanted = ({1'b0, ay_reg} < {ax_reg, 1'b0}) && ({ay_reg, 1'b0} > {1'b0, ax_reg});
        bigsq   = sq_reg > (2*PW+1)'(step_reg) * (2*PW+1)'(step_reg);
        if (slanted && bigsq) begin
            if (dx_reg > 0 && dy_reg > 0) d0c = tsg_pkg::DIR_RU;
            else if (dx_reg > 0 && dy_reg < 0) d0c = tsg_pkg::DIR_RD;
            else if (dx_reg < 0 && dy_reg > 0) d0c = tsg_pkg::DIR_LU;
            else d0c = tsg_pkg::DIR_LD;
        end else if (ax_reg > ay_reg && ax_reg > PW'(step_reg)) begin
            d0c = (dx_reg > 0) ? tsg_pkg::DIR_R : tsg_pkg::DIR_L;
        end else if (ay_reg > PW'(step_reg)) begin
            d0c = (dy_reg > 0) ? tsg_pkg::DIR_U : tsg_pkg::DIR_D;
        end else begin
            d0c = 8'd0;
        end
    end

    // Fill-in steps: with previous o, the model's rules reduce to a rotation
    // distance; previous zero adds nothing.
    logic [7:0] f1, f2;
    logic [2:0] rd;
    always_comb begin
        f1 = 8'd0;
        f2 = 8'd0;
        rd = tsg_pkg::dir_idx(d0_reg) - tsg_pkg::dir_idx(prev_reg);
        if (prev_reg != 8'd0) begin
            case (rd)
                3'd2: f1 = tsg_pkg::rot_ccw(prev_reg, 3'd1);
                3'd3: begin
                    f1 = tsg_pkg::rot_ccw(prev_reg, 3'd2);
                    f2 = tsg_pkg::rot_ccw(prev_reg, 3'd1);
                end
                3'd6: f1 = tsg_pkg::rot_ccw(d0_reg, 3'd1);
                3'd5: begin
                    f1 = tsg_pkg::rot_ccw(d0_reg, 3'd1);
                    f2 = tsg_pkg::rot_ccw(d0_reg, 3'd2);
                end
                default: ;
            endcase
        end
    end

    logic [CW:0] need;
    assign need = (CW+1)'(nstr_reg) + (CW+1)'(1) + (CW+1)'(d1_reg != 0) + (CW+1)'(d2_reg != 0);

    logic [IW-1:0] w0, w1, w2;
    assign w0 = nstr_reg[IW-1:0];
    assign w1 = IW'(nstr_reg + CW'(1));
    assign w2 = IW'(nstr_reg + CW'(2));

    logic [COORD_BITS-1:0] vx;
    assign vx = raw_reg[COORD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            armed_reg <= 1'b0;
            mask_reg  <= 3'd7;
            step_reg  <= 8'd5;
            mv_reg    <= 1'b0;
            cls_busy_reg <= 1'b0;
            hist_reg  <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            nstr_reg  <= '0;
            ncor_reg  <= '0;
            sx_reg <= '0; sy_reg <= '0; lx_reg <= '0; ly_reg <= '0;
            tx_reg <= '0; ty_reg <= '0; px_reg <= '0; py_reg <= '0;
            prev_reg  <= '0;
            xs_reg <= 1'b0; ys_reg <= 1'b0; havep_reg <= 1'b0;
            cid_reg   <= tsg_pkg::ID_NONE;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    tsg_pkg::CFG_ARMED: armed_reg <= cfg_data[0];
                    tsg_pkg::CFG_MASK:  mask_reg  <= cfg_data[2:0];
                    tsg_pkg::CFG_STEP:  step_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg  <= s_tdata[2:0];
                        raw_reg   <= s_tdata[19:3];
                        state_reg <= S_EVT;
                    end
                end
                S_EVT: begin
                    state_reg <= S_IDLE;
                    if (armed_reg) begin
                        case (kind_reg)
                            tsg_pkg::REQ_ID: begin
                                if (raw_reg == tsg_pkg::ID_NONE) begin
                                    state_reg <= S_CLS;
                                end else if (cid_reg == tsg_pkg::ID_NONE) begin
                                    cid_reg <= raw_reg;
                                end else if (cid_reg != raw_reg) begin
                                    hist_reg <= '0; cx_reg <= '0; cy_reg <= '0;
                                    nstr_reg <= '0; ncor_reg <= '0;
                                    sx_reg <= '0; sy_reg <= '0; lx_reg <= '0; ly_reg <= '0;
                                    tx_reg <= '0; ty_reg <= '0; px_reg <= '0; py_reg <= '0;
                                    prev_reg <= '0; xs_reg <= 1'b0; ys_reg <= 1'b0;
                                    havep_reg <= 1'b0; cid_reg <= tsg_pkg::ID_NONE;
                                end
                            end
                            tsg_pkg::REQ_SLOT: begin
                                hist_reg <= '0; cx_reg <= '0; cy_reg <= '0;
                                nstr_reg <= '0; ncor_reg <= '0;
                                sx_reg <= '0; sy_reg <= '0; lx_reg <= '0; ly_reg <= '0;
                                tx_reg <= '0; ty_reg <= '0; px_reg <= '0; py_reg <= '0;
                                prev_reg <= '0; xs_reg <= 1'b0; ys_reg <= 1'b0;
                                havep_reg <= 1'b0; cid_reg <= tsg_pkg::ID_NONE;
                            end
                            tsg_pkg::REQ_BTN: begin
                                if (raw_reg == '0) state_reg <= S_CLS;
                            end
                            tsg_pkg::REQ_X: begin
                                px_reg <= vx;
                                if (ys_reg) begin
                                    xs_reg <= 1'b0; ys_reg <= 1'b0;
                                    state_reg <= S_PT;
                                end else begin
                                    xs_reg <= 1'b1;
                                end
                            end
                            tsg_pkg::REQ_Y: begin
                                py_reg <= vx;
                                if (xs_reg) begin
                                    xs_reg <= 1'b0; ys_reg <= 1'b0;
                                    state_reg <= S_PT;
                                end else begin
                                    ys_reg <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_PT: begin
                    if (!havep_reg) begin
                        sx_reg <= px_reg; sy_reg <= py_reg;
                        havep_reg <= 1'b1;
                        dx_reg <= '0; dy_reg <= '0;
                        ax_reg <= '0; ay_reg <= '0;
                    end else begin
                        dx_reg <= (PW+1)'(px_reg) - (PW+1)'(lx_reg);
                        dy_reg <= (PW+1)'(ly_reg) - (PW+1)'(py_reg);
                        ax_reg <= (px_reg >= lx_reg) ? PW'(px_reg - lx_reg) : PW'(lx_reg - px_reg);
                        ay_reg <= (ly_reg >= py_reg) ? PW'(ly_reg - py_reg) : PW'(py_reg - ly_reg);
                    end
                    tx_reg <= px_reg; ty_reg <= py_reg;
                    lx_reg <= px_reg; ly_reg <= py_reg;
                    state_reg <= S_SQX;
                end
                S_SQX: begin
                    sq_reg    <= (2*PW+1)'(mul_p);
                    state_reg <= S_SQY;
                end
                S_SQY: begin
                    sq_reg    <= sq_reg + (2*PW+1)'(mul_p);
                    state_reg <= S_DIR;
                end
                S_DIR: begin
                    d0_reg <= d0c;
                    state_reg <= (d0c != 8'd0 && d0c != prev_reg) ? S_FILL : S_IDLE;
                    if (d0c != 8'd0 && d0c == prev_reg) prev_reg <= d0c;
                end
                S_FILL: begin
                    d1_reg <= f1;
                    d2_reg <= (f1 == 8'd0) ? 8'd0 : f2;
                    state_reg <= S_APP;
                end
                S_APP: begin
                    state_reg <= S_IDLE;
                    if (need > (CW+1)'(HISTORY_DEPTH)) begin
                        hist_reg <= '0; cx_reg <= '0; cy_reg <= '0;
                        nstr_reg <= '0; ncor_reg <= '0;
                        sx_reg <= '0; sy_reg <= '0; lx_reg <= '0; ly_reg <= '0;
                        tx_reg <= '0; ty_reg <= '0; px_reg <= '0; py_reg <= '0;
                        prev_reg <= '0; xs_reg <= 1'b0; ys_reg <= 1'b0;
                        havep_reg <= 1'b0; cid_reg <= tsg_pkg::ID_NONE;
                    end else begin
                        if (d2_reg != 0) begin
                            hist_reg[w0] <= d2_reg;
                            hist_reg[w1] <= d1_reg;
                            hist_reg[w2] <= d0_reg;
                        end else if (d1_reg != 0) begin
                            hist_reg[w0] <= d1_reg;
                            hist_reg[w1] <= d0_reg;
                        end else begin
                            hist_reg[w0] <= d0_reg;
                        end
                        nstr_reg <= CW'(need);
                        if (ncor_reg < CW'(HISTORY_DEPTH)) begin
                            cx_reg[ncor_reg[IW-1:0]] <= tx_reg;
                            cy_reg[ncor_reg[IW-1:0]] <= ty_reg;
                            ncor_reg <= ncor_reg + CW'(1);
                        end
                        prev_reg <= d0_reg;
                    end
                end
                S_CLS: begin
                    if (cls_start) begin
                        cls_busy_reg <= 1'b1;
                    end
                    if (cls_busy_reg && cls_done) begin
                        cls_busy_reg <= 1'b0;
                        mv_reg    <= 1'b1;
                        mdata_reg <= {2'b00, (nstr_reg > CW'(15)) ? 4'd15 : 4'(nstr_reg), cls_gest};
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    hist_reg <= '0; cx_reg <= '0; cy_reg <= '0;
                    nstr_reg <= '0; ncor_reg <= '0;
                    sx_reg <= '0; sy_reg <= '0; lx_reg <= '0; ly_reg <= '0;
                    tx_reg <= '0; ty_reg <= '0; px_reg <= '0; py_reg <= '0;
                    prev_reg <= '0; xs_reg <= 1'b0; ys_reg <= 1'b0;
                    havep_reg <= 1'b0; cid_reg <= tsg_pkg::ID_NONE;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    logic unused_cx;
    assign unused_cx = ^cx_reg;

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn) nstr_reg <= CW'(HISTORY_DEPTH);
    endproperty
    a_count: assert property (p_count_bound) else $error("history count overflow");
    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn) (m_tvalid && !m_tready) |=> m_tvalid;
    endproperty
    a_out: assert property (p_out_hold) else $error("result beat dropped");
    property p_busy;
        @(posedge aclk) disable iff (!aresetn) (state_reg != S_IDLE) |-> !s_tready;
    endproperty
    a_busy: assert property (p_busy) else $error("ready while busy");
endmodule

/* tb/tb_top.sv */
// Self-checking testbench of the touch stroke gesture recognizer with a built-in predictor.
`timescale 1ns / 100ps

module tb_top;

    typedef struct packed {
        logic [16:0] value;
        logic [2:0]  kind;
    } touch_event_t;

    typedef struct packed {
        logic [3:0] strokes;
        logic [1:0] gesture;
    } gesture_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    touch_event_t    pending_events[$];
    gesture_result_t expected_gestures[$];
    int  mismatches = 0;
    bit  failed = 1'b0;
    bit  calm = 1'b0;
    bit  rx_hold = 1'b0;

    // Predictor configuration and state.
    int  armed_q, mask_q, step_q;
    int  hist[15], cxs[15], cys[15];
    int  sx, sy, lpx, lpy, ltx, lty, prev_hd, px, py, nst, ncor;
    bit  xs, ys, havept;
    int  cid;

    always #1 aclk = ~aclk;

    touch_stroke_gesture_recognizer u_top (.*);

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void wipe_track();
        for (int i = 0; i < 15; i++) begin
            hist[i] = 0;
            cxs[i] = 0;
            cys[i] = 0;
        end
        sx = 0; sy = 0; lpx = 0; lpy = 0; ltx = 0; lty = 0;
        prev_hd = 0; px = 0; py = 0; xs = 0; ys = 0;
        cid = int'(tsg_pkg::ID_NONE); nst = 0; ncor = 0; havept = 0;
    endfunction

    function automatic bit circle_shape(int count);
        int turn, total, low_y, g, n, cy;
        bit hit;
        turn = 0; total = 0; low_y = 0;
        for (int i = 0; i + 1 < count; i++) begin
            g = hist[i];
            n = hist[i + 1];
            hit = 0;
            if ((2 * g == n || (g == 128 && n == 1)) && turn < 1) begin
                turn = -1; hit = 1;
            end else if ((g == 2 * n || (n == 128 && g == 1)) && turn > -1) begin
                turn = 1; hit = 1;
            end
            if (hit) begin
                cy = cys[i];
                total += g;
                if (cy != 0 && cy > low_y) low_y = cy;
            end
            if (total == 255 && lty < low_y + 50) return 1;
            if (total > 255) return 0;
        end
        return 0;
    endfunction

    function automatic bit m_shape(int count);
        int total, g, n;
        bit lower;
        total = 0; lower = 0;
        for (int i = 0; i + 1 < count; i++) begin
            g = hist[i];
            n = hist[i + 1];
            if (!lower && (g == 2 * n || (g == 1 && n == 128) || (g == 64 && n == 4))) begin
                total += g;
                if (i + 2 == count) begin
                    total += n;
                    i += 1;
                end
            end else if (!lower && g == 64 && n == 128 &&
                         (total + 64 == 199 || total + 64 == 195)) begin
                total += g;
                lower = 1;
            end else if (lower && ((g == 128 && n == 1) || (g == 1 && n == 2))) begin
                total += g;
                if (total == 328 && g == 1) lower = 0;
            end
            if ((total == 398 && i == 9) || (total == 394 && i == 8) ||
                (total == 334 && i == 8) || (total == 330 && i == 7) ||
                (total == 529 && i == 12) || (total == 525 && i == 11) ||
                (total == 465 && i == 11) || (total == 461 && i == 10))
                return 1;
        end
        return 0;
    endfunction

    function automatic void classify_lift();
        int count, total, ddx, ddy;
        gesture_result_t r;
        logic [1:0] g;
        count = nst; total = 0; g = tsg_pkg::GEST_NONE;
        for (int i = 0; i < count; i++) total += hist[i];
        if (count > 8 && circle_shape(count) && mask_q[1]) g = tsg_pkg::GEST_O;
        if (count > 6 && g == tsg_pkg::GEST_NONE) begin
            ddx = iabs(ltx - sx);
            ddy = iabs(lty - sy);
            if (ddx > 40 && ddy > 40 && ((count == 9 && total == 256) ||
                (count == 8 && total == 255) || (count == 7 && total == 254)) && mask_q[0])
                g = tsg_pkg::GEST_E;
            else if (m_shape(count) && mask_q[2])
                g = tsg_pkg::GEST_M;
        end
        r.gesture = g;
        r.strokes = count > 15 ? 4'd15 : 4'(count);
        expected_gestures.push_back(r);
        wipe_track();
    endfunction

    function automatic void track_point(int x, int y);
        int dx, dy, ax, ay, d0, d1, d2, o, k, i;
        bit slanted;
        d1 = 0; d2 = 0; o = prev_hd;
        if (!havept) begin
            sx = x; sy = y; lpx = x; lpy = y; havept = 1;
        end
        ltx = x; lty = y;
        dx = x - lpx;
        dy = lpy - y;
        ax = iabs(dx); ay = iabs(dy);
        slanted = ay < 2 * ax && 2 * ay > ax;
        if (slanted && ax * ax + ay * ay > step_q * step_q) begin
            if (dx > 0 && dy > 0) d0 = tsg_pkg::DIR_RU;
            else if (dx > 0 && dy < 0) d0 = tsg_pkg::DIR_RD;
            else if (dx < 0 && dy > 0) d0 = tsg_pkg::DIR_LU;
            else d0 = tsg_pkg::DIR_LD;
        end else if (ax > ay && ax > step_q) begin
            d0 = dx > 0 ? tsg_pkg::DIR_R : tsg_pkg::DIR_L;
        end else if (ay > step_q) begin
            d0 = dy > 0 ? tsg_pkg::DIR_U : tsg_pkg::DIR_D;
        end else begin
            d0 = 0;
        end
        lpx = x; lpy = y;
        if (d0 != 0 && d0 != o) begin
            if ((d0 > o && d0 < 32 * o) || (d0 == 1 && o == 64) || (d0 == 2 && o == 128) ||
                32 * d0 == o) begin
                if (d0 == 8 * o) begin d1 = 4 * o; d2 = 2 * o; end
                else if (d0 == 1 && o == 32) begin d1 = 128; d2 = 64; end
                else if (d0 == 2 && o == 64) begin d1 = 1; d2 = 128; end
                else if (d0 == 4 && o == 128) begin d1 = 2; d2 = 1; end
                else if (d0 == 4 * o) d1 = 2 * o;
                else if (d0 == 1 && o == 64) d1 = 128;
                else if (d0 == 2 && o == 128) d1 = 1;
            end else if (d0 < o || (o == 1 && d0 == 64) || (o == 2 && d0 == 128) ||
                         d0 == 32 * o) begin
                if (8 * d0 == o) begin d1 = 2 * d0; d2 = 4 * d0; end
                else if (d0 == 32 && o == 1) begin d1 = 64; d2 = 128; end
                else if (d0 == 64 && o == 2) begin d1 = 128; d2 = 1; end
                else if (d0 == 128 && o == 4) begin d1 = 1; d2 = 2; end
                else if (4 * d0 == o) d1 = 2 * d0;
                else if (o == 1 && d0 == 64) d1 = 128;
                else if (o == 2 && d0 == 128) d1 = 1;
            end
            if (d1 == 0) d2 = 0;
            k = 1 + (d1 != 0) + (d2 != 0);
            if (nst + k > 15) begin
                wipe_track();
                return;
            end
            i = nst;
            if (d2 != 0) begin
                hist[i] = d2;
                i = i + 1;
            end
            if (d1 != 0) begin
                hist[i] = d1;
                i = i + 1;
            end
            hist[i] = d0;
            nst = i + 1;
            if (ncor < 15) begin
                cxs[ncor] = x;
                cys[ncor] = y;
                ncor = ncor + 1;
            end
        end
        if (d0 != 0) prev_hd = d0;
    endfunction

    function automatic void predict_event(touch_event_t ev);
        int raw;
        raw = int'(ev.value);
        if (armed_q == 0) return;
        case (ev.kind)
            tsg_pkg::REQ_ID: begin
                if (ev.value == tsg_pkg::ID_NONE) classify_lift();
                else if (cid == int'(tsg_pkg::ID_NONE)) cid = raw;
                else if (cid != raw) wipe_track();
            end
            tsg_pkg::REQ_SLOT: wipe_track();
            tsg_pkg::REQ_BTN: if (raw == 0) classify_lift();
            tsg_pkg::REQ_X, tsg_pkg::REQ_Y: begin
                if (ev.kind == tsg_pkg::REQ_X) begin
                    px = raw & 12'hFFF; xs = 1;
                end else begin
                    py = raw & 12'hFFF; ys = 1;
                end
                if (xs && ys) begin
                    xs = 0; ys = 0;
                    track_point(px, py);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic bit idle_now();
        return !calm && $urandom_range(99) < 8;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_event(touch_event_t'(s_tdata[19:0]));
            if ((!s_tvalid || s_tready) ) begin
                if (pending_events.size() > 0 && !idle_now()) begin
                    s_tdata  <= {4'b0, pending_events.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        gesture_result_t got, want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = gesture_result_t'(m_tdata[5:0]);
                if (expected_gestures.size() == 0) begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: gesture %0d count %0d",
                                 got.gesture, got.strokes);
                end else begin
                    want = expected_gestures.pop_front();
                    if (got !== want) begin
                        failed = 1'b1;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected gesture %0d count %0d, got %0d %0d",
                                     want.gesture, want.strokes, got.gesture, got.strokes);
                    end
                end
            end
            m_tready <= !rx_hold && !idle_now();
        end
    end

    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 8'(val);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tsg_pkg::CFG_ARMED: armed_q = val & 1;
            tsg_pkg::CFG_MASK:  mask_q = val & 7;
            default:            step_q = val & 255;
        endcase
    endtask

    task automatic add_event(logic [2:0] kind, int val);
        touch_event_t ev;
        ev.kind = kind;
        ev.value = 17'(val);
        pending_events.push_back(ev);
    endtask

    task automatic add_point(int x, int y);
        if ($urandom_range(3) == 0) begin
            add_event(tsg_pkg::REQ_Y, y);
            add_event(tsg_pkg::REQ_X, x);
        end else begin
            add_event(tsg_pkg::REQ_X, x);
            add_event(tsg_pkg::REQ_Y, y);
        end
    endtask

    // One finger stroke that turns in 45-degree steps, mostly one way round.
    task automatic add_stroke();
        int dxs[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
        int dys[8] = '{0, -1, -1, -1, 0, 1, 1, 1};
        int x, y, h, spin, len, npts, r;
        x = $urandom_range(300, 3800);
        y = $urandom_range(300, 3800);
        h = $urandom_range(7);
        spin = $urandom_range(1) ? 1 : 7;
        npts = $urandom_range(2, 14);
        if ($urandom_range(3) != 0) add_event(tsg_pkg::REQ_ID, $urandom_range(0, 20));
        add_point(x, y);
        for (int i = 0; i < npts; i++) begin
            r = $urandom_range(9);
            if (r < 6) h = (h + spin) % 8;
            else if (r == 6) h = (h + 8 - spin) % 8;
            len = $urandom_range(4, 90);
            x += dxs[h] * len + $urandom_range(4) - 2;
            y += dys[h] * len + $urandom_range(4) - 2;
            if ($urandom_range(19) == 0) add_event(tsg_pkg::REQ_X, $urandom_range(0, 4095));
            add_point(x, y);
            if ($urandom_range(39) == 0) begin
                case ($urandom_range(3))
                    0: add_event(tsg_pkg::REQ_SLOT, $urandom_range(0, 131071));
                    1: add_event(tsg_pkg::REQ_ID, $urandom_range(0, 131071));
                    2: add_event(tsg_pkg::REQ_BTN, $urandom_range(1, 131071));
                    default: add_event(3'($urandom_range(5, 7)), $urandom_range(0, 131071));
                endcase
            end
        end
        if ($urandom_range(9) == 0)
            add_event(tsg_pkg::REQ_X, $urandom_range(0, 131071));
        if ($urandom_range(1)) add_event(tsg_pkg::REQ_ID, -1);
        else add_event(tsg_pkg::REQ_BTN, 0);
    endtask

    task automatic drain();
        wait (pending_events.size() == 0);
        @(posedge aclk);
        while (s_tvalid || expected_gestures.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic run_phase(int items);
        int goal;
        goal = pending_events.size() + items;
        @(negedge aclk);
        while (pending_events.size() < goal) add_stroke();
        drain();
    endtask

    initial begin
        armed_q = 0; mask_q = 7; step_q = 5;
        wipe_track();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(tsg_pkg::CFG_ARMED, 1);
        @(negedge aclk);
        add_event(tsg_pkg::REQ_ID, -1);
        add_event(tsg_pkg::REQ_BTN, 0);
        add_event(tsg_pkg::REQ_X, 0);
        add_event(tsg_pkg::REQ_Y, 0);
        add_event(tsg_pkg::REQ_X, 4095);
        add_event(tsg_pkg::REQ_Y, 4095);
        add_event(tsg_pkg::REQ_X, -1);
        add_event(tsg_pkg::REQ_Y, 65535);
        add_event(tsg_pkg::REQ_ID, 7);
        add_event(tsg_pkg::REQ_ID, 9);
        add_event(tsg_pkg::REQ_X, 100);
        add_event(tsg_pkg::REQ_Y, 100);
        add_event(tsg_pkg::REQ_X, 200);
        add_event(tsg_pkg::REQ_Y, 40);
        add_event(tsg_pkg::REQ_SLOT, 0);
        add_event(tsg_pkg::REQ_BTN, 1);
        add_event(tsg_pkg::REQ_BTN, 65535);
        add_event(5, 0);
        add_event(6, -1);
        add_event(7, 43690);
        add_event(tsg_pkg::REQ_X, 300);
        add_event(tsg_pkg::REQ_Y, 300);
        add_event(tsg_pkg::REQ_X, 360);
        add_event(tsg_pkg::REQ_Y, 300);
        add_event(tsg_pkg::REQ_BTN, 0);
        drain();

        calm = 1'b1;
        run_phase(250);
        calm = 1'b0;
        fork
            begin
                @(negedge aclk);
                rx_hold = 1'b1;
                repeat (500) @(negedge aclk);
                rx_hold = 1'b0;
            end
            run_phase(250);
        join
        write_reg(tsg_pkg::CFG_STEP, 0);
        write_reg(tsg_pkg::CFG_MASK, 0);
        run_phase(150);
        write_reg(tsg_pkg::CFG_STEP, 255);
        write_reg(tsg_pkg::CFG_MASK, 7);
        run_phase(100);
        write_reg(tsg_pkg::CFG_ARMED, 0);
        run_phase(100);
        write_reg(tsg_pkg::CFG_ARMED, 1);
        write_reg(tsg_pkg::CFG_STEP, 5);
        for (int m = 1; m < 7; m++) begin
            write_reg(tsg_pkg::CFG_MASK, m);
            write_reg(tsg_pkg::CFG_STEP, $urandom_range(0, 30));
            run_phase(115);
        end

        if (!failed) $display("** touch_stroke_gesture_recognizer: PASSED **");
        else $display("** touch_stroke_gesture_recognizer: FAILED **");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** touch_stroke_gesture_recognizer: FAILED **");
        $finish;
    end

endmodule
